// ===== sv/udpck_pkg.sv =====
// Package for the UDP / UDP-Lite checksum engine.
// Holds the operation codes, the protocol and coverage constants and the item type
// passed from the input register to the checksum core. No dependencies.
package udpck_pkg;

    // Operation codes: bit 1 selects UDP-Lite, bit 0 selects verify.
    typedef enum logic [1:0] {
        OP_UDP_GEN     = 2'd0,
        OP_UDP_VERIFY  = 2'd1,
        OP_LITE_GEN    = 2'd2,
        OP_LITE_VERIFY = 2'd3
    } op_t;

    localparam logic [7:0]  UDP_PROTO       = 8'd17;
    localparam logic [7:0]  UDPLITE_PROTO   = 8'd136;
    localparam logic [15:0] CKSUM_ZERO_AS   = 16'hFFFF;
    localparam logic [15:0] UDPLITE_COV_ALL = 16'd0;
    localparam logic [15:0] UDPLITE_COV_MIN = 16'd8;
    localparam logic [15:0] INDEX_MAX       = 16'hFFFF;

    // Pseudo-header sum: five 16-bit terms and the protocol fit in 19 bits.
    localparam int PSEUDO_W = 19;

    // One octet with everything precomputed that depends only on its own fields.
    typedef struct packed {
        op_t                 op;
        logic [15:0]         span_limit;
        logic                coverage_ok;
        logic [PSEUDO_W-1:0] pseudo_sum;
        logic [7:0]          data_byte;
        logic                last;
    } item_t;

    // Control between the input register and the core.
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

// ===== sv/udpck_in_if.sv =====
// Input channel of the checksum engine: one datagram octet per transfer.
// Carries valid, ready and the octet with its datagram fields. No dependencies.
interface udpck_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] total_len;
    logic [15:0] coverage;
    logic [7:0]  data_byte;
    logic        last;

    modport source (
        output valid, op, src_addr, dst_addr, total_len, coverage, data_byte, last,
        input  ready
    );
    modport sink (
        input  valid, op, src_addr, dst_addr, total_len, coverage, data_byte, last,
        output ready
    );
endinterface

// ===== sv/udpck_out_if.sv =====
// Result channel of the checksum engine: one result per datagram.
// Carries valid, ready and the checksum with its status flags. No dependencies.
interface udpck_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    logic        check_ok;
    logic        coverage_ok;

    modport source (
        output valid, checksum, check_ok, coverage_ok,
        input  ready
    );
    modport sink (
        input  valid, checksum, check_ok, coverage_ok,
        output ready
    );
endinterface

// ===== sv/udp_udplite_checksum_engine_unit.sv =====
// UDP / UDP-Lite checksum engine: one result per datagram, held in the result register.
// Throughput: one octet per cycle, set by the single add into the running sum, unless
// a final octet waits on a blocked result register. Octets enter via the input register.
// Reset: asynchronous, active low; clears all control state, no datagram in progress.
// Depends on udpck_pkg, udpck_in_if, udpck_out_if, udpck_in_stage and udpck_core.
module udp_udplite_checksum_engine_unit (
    input  logic         clk,
    input  logic         rst_n,
    udpck_in_if.sink     datagram,
    udpck_out_if.source  result
);
    import udpck_pkg::*;

    stage_t stage;
    logic   take;

    // Input register with the per-octet precomputation.
    udpck_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .datagram (datagram),
        .take     (take),
        .stage    (stage)
    );

    // Running sum and result register.
    udpck_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .take   (take),
        .result (result)
    );

endmodule

// ===== sv/udpck_in_stage.sv =====
// Input register of the checksum engine: pseudo-header sum, span and coverage check.
// Depends on udpck_pkg and udpck_in_if.
module udpck_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    udpck_in_if.sink         datagram,
    input  logic             take,
    output udpck_pkg::stage_t stage
);
    import udpck_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    item_t  item_reg;
    item_t  item_next;
    logic   lite;
    logic   accept;

    assign lite            = datagram.op[1];
    assign datagram.ready  = !valid_reg || take;
    assign accept          = datagram.valid && datagram.ready;

    // Work out everything that depends on the octet's own fields.
    always_comb
    begin
        item_next.op        = op_t'(datagram.op);
        item_next.data_byte = datagram.data_byte;
        item_next.last      = datagram.last;
        if (lite && datagram.coverage != UDPLITE_COV_ALL)
        begin
            item_next.span_limit = datagram.coverage;
        end
        else
        begin
            item_next.span_limit = datagram.total_len;
        end
        item_next.pseudo_sum =
            PSEUDO_W'(datagram.src_addr[31:16]) + PSEUDO_W'(datagram.src_addr[15:0])
          + PSEUDO_W'(datagram.dst_addr[31:16]) + PSEUDO_W'(datagram.dst_addr[15:0])
          + PSEUDO_W'(lite ? UDPLITE_PROTO : UDP_PROTO) + PSEUDO_W'(datagram.total_len);
        // UDP-Lite needs room for a header; a nonzero coverage must span the header and fit the length.
        if (!lite)
        begin
            item_next.coverage_ok = 1'b1;
        end
        else if (datagram.total_len < UDPLITE_COV_MIN)
        begin
            item_next.coverage_ok = 1'b0;
        end
        else if (datagram.coverage == UDPLITE_COV_ALL)
        begin
            item_next.coverage_ok = 1'b1;
        end
        else
        begin
            item_next.coverage_ok = (datagram.coverage >= UDPLITE_COV_MIN)
                                 && (datagram.coverage <= datagram.total_len);
        end
    end

    // The register holds one octet until the core takes it.
    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ===== sv/udpck_core.sv =====
// Checksum core: running one's-complement sum over the span and the result register.
// Depends on udpck_pkg and udpck_out_if.
module udpck_core (
    input  logic              clk,
    input  logic              rst_n,
    input  udpck_pkg::stage_t stage,
    output logic              take,
    udpck_out_if.source       result
);
    import udpck_pkg::*;

    logic        in_dgram_reg;
    logic        in_dgram_next;
    logic [15:0] index_reg;
    logic [15:0] index_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [7:0]  pend_reg;
    logic [7:0]  pend_next;
    op_t         op_reg;
    op_t         op_next;
    logic [15:0] span_reg;
    logic [15:0] span_next;
    logic        covok_reg;
    logic        covok_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] checksum_reg;
    logic [15:0] checksum_next;
    logic        check_ok_reg;
    logic        check_ok_next;
    logic        coverage_ok_reg;
    logic        coverage_ok_next;

    item_t       it;
    logic [15:0] cur_index;
    logic [31:0] cur_acc;
    logic [7:0]  cur_pend;
    op_t         cur_op;
    logic [15:0] cur_span;
    logic        cur_covok;
    logic [15:0] add_word;
    logic [31:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] raw;
    logic        finish;

    assign it = stage.item;

    // An octet moves on unless it ends a datagram and the result register is blocked.
    assign take   = stage.valid && (!it.last || !out_valid_reg || result.ready);
    assign finish = take && it.last;

    // The first octet of a datagram starts from the pseudo-header sum.
    always_comb
    begin
        if (!in_dgram_reg)
        begin
            cur_index = 16'd0;
            cur_acc   = 32'(it.pseudo_sum);
            cur_pend  = 8'd0;
            cur_op    = it.op;
            cur_span  = it.span_limit;
            cur_covok = it.coverage_ok;
        end
        else
        begin
            cur_index = index_reg;
            cur_acc   = acc_reg;
            cur_pend  = pend_reg;
            cur_op    = op_reg;
            cur_span  = span_reg;
            cur_covok = covok_reg;
        end
    end

    // Word to add: a full pair, a padded final octet, or a held octet past the span.
    always_comb
    begin
        add_word  = 16'd0;
        pend_next = cur_pend;
        if (cur_index < cur_span)
        begin
            if (cur_index[0])
            begin
                add_word = {cur_pend, it.data_byte};
            end
            else
            begin
                pend_next = it.data_byte;
                if (it.last)
                begin
                    add_word = {it.data_byte, 8'd0};
                end
            end
        end
        else if (it.last && cur_span[0])
        begin
            add_word = {cur_pend, 8'd0};
        end
        sum   = cur_acc + 32'(add_word);
        fold1 = {1'b0, sum[15:0]} + {1'b0, sum[31:16]};
        fold2 = fold1[15:0] + 16'(fold1[16]);
        raw   = ~fold2;
    end

    // Running state update for each octet taken.
    always_comb
    begin
        in_dgram_next = in_dgram_reg;
        index_next    = index_reg;
        acc_next      = acc_reg;
        op_next       = op_reg;
        span_next     = span_reg;
        covok_next    = covok_reg;
        if (take)
        begin
            op_next    = cur_op;
            span_next  = cur_span;
            covok_next = cur_covok;
            if (it.last)
            begin
                in_dgram_next = 1'b0;
                index_next    = 16'd0;
                acc_next      = 32'd0;
            end
            else
            begin
                in_dgram_next = 1'b1;
                index_next    = (cur_index == INDEX_MAX) ? cur_index : cur_index + 16'd1;
                acc_next      = sum;
            end
        end
    end

    // Result register: loaded on the final octet, held until the transfer.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        checksum_next    = checksum_reg;
        check_ok_next    = check_ok_reg;
        coverage_ok_next = coverage_ok_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next   = 1'b1;
            coverage_ok_next = cur_covok;
            case (cur_op)
                OP_UDP_VERIFY, OP_LITE_VERIFY:
                begin
                    checksum_next = raw;
                    check_ok_next = (raw == 16'd0);
                end
                OP_UDP_GEN, OP_LITE_GEN:
                begin
                    checksum_next = (raw == 16'd0) ? CKSUM_ZERO_AS : raw;
                    check_ok_next = 1'b0;
                end
                default:
                begin
                    checksum_next = raw;
                    check_ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_dgram_reg  <= 1'b0;
            index_reg     <= 16'd0;
            acc_reg       <= 32'd0;
            op_reg        <= OP_UDP_GEN;
            span_reg      <= 16'd0;
            covok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_dgram_reg  <= in_dgram_next;
            index_reg     <= index_next;
            acc_reg       <= acc_next;
            op_reg        <= op_next;
            span_reg      <= span_next;
            covok_reg     <= covok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_reg <= pend_next;
        end
        checksum_reg    <= checksum_next;
        check_ok_reg    <= check_ok_next;
        coverage_ok_reg <= coverage_ok_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.checksum    = checksum_reg;
    assign result.check_ok    = check_ok_reg;
    assign result.coverage_ok = coverage_ok_reg;

endmodule
